// ===== hw/rtl/pid_controller_clamped_integrator_assert.svh =====
// Assertion macros used by the checker of this block.
`ifndef PID_CONTROLLER_CLAMPED_INTEGRATOR_ASSERT_SVH
`define PID_CONTROLLER_CLAMPED_INTEGRATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PIDC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pidc assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define PIDC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pidc assertion failed");

`endif

// ===== hw/rtl/pidc_pkg.sv =====
package pidc_pkg;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_AREA,
      ST_INTEG,
      ST_CLAMP,
      ST_DIV_D,
      ST_DERIV,
      ST_MUL_I,
      ST_LOAD_I,
      ST_DIG_MUL,
      ST_DIG_SUB,
      ST_IQUOT,
      ST_DTERM,
      ST_DM1,
      ST_DM2,
      ST_DM3,
      ST_FINISH
   } pidc_state_type;

   localparam int CSR_INDEX_WIDTH = 3;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_PROP_GAIN        = 3'd0,
      CSR_INTEG_GAIN       = 3'd1,
      CSR_DERIV_GAIN       = 3'd2,
      CSR_INTEG_LOW_LIMIT  = 3'd3,
      CSR_INTEG_HIGH_LIMIT = 3'd4,
      CSR_SAMPLE_PERIOD    = 3'd5
   } pidc_csr_type;

   localparam logic [30:0] INTEG_DIVISOR = 31'd1000;
   localparam int DIGIT_WIDTH = 16;
   localparam int IREM_WIDTH = 10;
   localparam int IRECIP_SHIFT = 36;
   localparam logic [26:0] INTEG_RECIP = 27'd68719477;
   localparam logic signed [63:0] DTERM_LIMIT = 64'sd2305843009213693;
   localparam logic signed [31:0] DRIVE_MAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] DRIVE_MIN = 32'sh8000_0000;

endpackage

// ===== hw/rtl/pid_controller_clamped_integrator.sv =====
// The block takes a new request beat only while idle; it stalls its input until the
// response of the previous beat has been loaded into the response register.
// The restoring divider takes 33+FRAC_BITS steps for the derivative; the divide by 1000
// runs a multiply state and a subtract state per 16-bit digit (three digits by default).
// Synchronous active-high reset idles the sequencer, drops response valid, zeroes the
// error history and integrator and restores the gain, limit and sample period defaults.
module pid_controller_clamped_integrator #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [31:0]                     req_error_sample,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [31:0]                     rsp_drive_value,
   output logic                                   rsp_drive_saturated,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [pidc_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [31:0]                            csr_data
);

   localparam int DERIV_WIDTH = 33 + FRAC_BITS;
   localparam int ITERM_WIDTH = 63 - FRAC_BITS;
   localparam int DIV_WIDTH = DERIV_WIDTH;
   localparam int CNT_WIDTH = $clog2(DIV_WIDTH + 1);
   localparam int IDIGITS = (ITERM_WIDTH + pidc_pkg::DIGIT_WIDTH - 1) / pidc_pkg::DIGIT_WIDTH;
   localparam int IQ_WIDTH = IDIGITS * pidc_pkg::DIGIT_WIDTH;
   localparam int DIGX_WIDTH = pidc_pkg::IREM_WIDTH + pidc_pkg::DIGIT_WIDTH;
   localparam logic [DIV_WIDTH-1:0] QUOT_NEG_LIMIT = DIV_WIDTH'(64'h8000_0000);
   localparam logic [DIV_WIDTH-1:0] QUOT_POS_LIMIT = DIV_WIDTH'(64'h7fff_ffff);

   pidc_pkg::pidc_state_type state_ff, state_in;

   logic signed [31:0] prop_gain_ff, integ_gain_ff, deriv_gain_ff;
   logic signed [31:0] low_limit_ff, high_limit_ff;
   logic [30:0]        sample_period_ff;

   logic signed [31:0] err_ff, prev_ff, integ_ff, deriv_ff;
   logic signed [32:0] sum_ff, diff_ff;
   logic signed [65:0] prod_ff;
   logic signed [63:0] acc_ff, term_ff;

   logic [30:0]           rem_ff, divisor_ff;
   logic [DIV_WIDTH-1:0]  dvd_ff;
   logic [IQ_WIDTH-1:0]   iq_ff;
   logic [CNT_WIDTH-1:0]  cnt_ff;
   logic                  neg_ff;

   logic                  rsp_valid_ff, rsp_sat_ff;
   logic signed [31:0]    rsp_value_ff;

   logic req_accept, rsp_load, div_step;
   logic [30:0] dt_eff;
   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] mul_prod, area_full, scaled_full;
   logic signed [63:0] area, scaled, integ_sum, clamp_val, low64, high64;
   logic signed [63:0] iterm, dterm_sat, drive_sum;
   logic [32:0]  diff_mag;
   logic [63:0]  scaled_mag, quot_ext;
   logic [31:0]  rem_shift, rem_diff;
   logic         rem_fits;
   logic [DIGX_WIDTH-1:0] dig_x, dig_rem;
   logic [pidc_pkg::DIGIT_WIDTH-1:0] dig_q;
   logic signed [31:0] deriv_sat, drive_val;
   logic         drive_flag;

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_drive_value = rsp_value_ff;
   assign rsp_drive_saturated = rsp_sat_ff;
   assign req_accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff     <= '0;
         integ_gain_ff    <= '0;
         deriv_gain_ff    <= '0;
         low_limit_ff     <= pidc_pkg::DRIVE_MIN;
         high_limit_ff    <= pidc_pkg::DRIVE_MAX;
         sample_period_ff <= 31'(1) << FRAC_BITS;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            pidc_pkg::CSR_PROP_GAIN:        prop_gain_ff     <= $signed(csr_data);
            pidc_pkg::CSR_INTEG_GAIN:       integ_gain_ff    <= $signed(csr_data);
            pidc_pkg::CSR_DERIV_GAIN:       deriv_gain_ff    <= $signed(csr_data);
            pidc_pkg::CSR_INTEG_LOW_LIMIT:  low_limit_ff     <= $signed(csr_data);
            pidc_pkg::CSR_INTEG_HIGH_LIMIT: high_limit_ff    <= $signed(csr_data);
            pidc_pkg::CSR_SAMPLE_PERIOD:    sample_period_ff <= csr_data[30:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pidc_pkg::ST_IDLE:     if (req_accept) state_in = pidc_pkg::ST_MUL_AREA;
         pidc_pkg::ST_MUL_AREA: state_in = pidc_pkg::ST_INTEG;
         pidc_pkg::ST_INTEG:    state_in = pidc_pkg::ST_CLAMP;
         pidc_pkg::ST_CLAMP:    state_in = pidc_pkg::ST_DIV_D;
         pidc_pkg::ST_DIV_D:    if (cnt_ff == CNT_WIDTH'(1)) state_in = pidc_pkg::ST_DERIV;
         pidc_pkg::ST_DERIV:    state_in = pidc_pkg::ST_MUL_I;
         pidc_pkg::ST_MUL_I:    state_in = pidc_pkg::ST_LOAD_I;
         pidc_pkg::ST_LOAD_I:   state_in = pidc_pkg::ST_DIG_MUL;
         pidc_pkg::ST_DIG_MUL:  state_in = pidc_pkg::ST_DIG_SUB;
         pidc_pkg::ST_DIG_SUB: begin
            if (cnt_ff == CNT_WIDTH'(1)) state_in = pidc_pkg::ST_IQUOT;
            else state_in = pidc_pkg::ST_DIG_MUL;
         end
         pidc_pkg::ST_IQUOT:    state_in = pidc_pkg::ST_DTERM;
         pidc_pkg::ST_DTERM:    state_in = pidc_pkg::ST_DM1;
         pidc_pkg::ST_DM1:      state_in = pidc_pkg::ST_DM2;
         pidc_pkg::ST_DM2:      state_in = pidc_pkg::ST_DM3;
         pidc_pkg::ST_DM3:      state_in = pidc_pkg::ST_FINISH;
         pidc_pkg::ST_FINISH:   if (rsp_load) state_in = pidc_pkg::ST_IDLE;
         default:               state_in = pidc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      rsp_load  = 1'b0;
      div_step  = 1'b0;
      case (state_ff)
         pidc_pkg::ST_IDLE:   req_stall = 1'b0;
         pidc_pkg::ST_DIV_D:  div_step = 1'b1;
         pidc_pkg::ST_FINISH: rsp_load = !rsp_valid_ff || !rsp_stall;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pidc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign dt_eff = (sample_period_ff == '0) ? 31'd1 : sample_period_ff;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         pidc_pkg::ST_MUL_AREA: begin
            mul_a = sum_ff;
            mul_b = $signed({2'b00, dt_eff});
         end
         pidc_pkg::ST_DERIV: begin
            mul_a = $signed({prop_gain_ff[31], prop_gain_ff});
            mul_b = $signed({err_ff[31], err_ff});
         end
         pidc_pkg::ST_MUL_I: begin
            mul_a = $signed({integ_gain_ff[31], integ_gain_ff});
            mul_b = $signed({integ_ff[31], integ_ff});
         end
         pidc_pkg::ST_DIG_MUL: begin
            mul_a = $signed(33'(dig_x));
            mul_b = $signed(33'(pidc_pkg::INTEG_RECIP));
         end
         pidc_pkg::ST_IQUOT: begin
            mul_a = $signed({deriv_gain_ff[31], deriv_gain_ff});
            mul_b = $signed({deriv_ff[31], deriv_ff});
         end
         default: ;
      endcase
   end

   assign mul_prod    = mul_a * mul_b;
   assign area_full   = prod_ff >>> (FRAC_BITS + 1);
   assign scaled_full = prod_ff >>> FRAC_BITS;
   assign area        = $signed(area_full[63:0]);
   assign scaled      = $signed(scaled_full[63:0]);
   assign integ_sum   = $signed({{32{integ_ff[31]}}, integ_ff}) + area;
   assign diff_mag    = diff_ff[32] ? 33'(-diff_ff) : 33'(diff_ff);
   assign scaled_mag  = scaled[63] ? 64'(-scaled) : 64'(scaled);
   assign low64       = $signed({{32{low_limit_ff[31]}}, low_limit_ff});
   assign high64      = $signed({{32{high_limit_ff[31]}}, high_limit_ff});

   always_comb begin
      clamp_val = acc_ff;
      if (clamp_val < low64) clamp_val = low64;
      if (clamp_val > high64) clamp_val = high64;
   end

   assign rem_shift = {rem_ff, dvd_ff[DIV_WIDTH-1]};
   assign rem_fits  = rem_shift >= {1'b0, divisor_ff};
   assign rem_diff  = rem_fits ? (rem_shift - {1'b0, divisor_ff}) : rem_shift;

   // The divide by 1000 runs one 16-bit digit at a time with a reciprocal multiply.
   assign dig_x   = {rem_ff[pidc_pkg::IREM_WIDTH-1:0],
                     iq_ff[IQ_WIDTH-1 -: pidc_pkg::DIGIT_WIDTH]};
   assign dig_q   = prod_ff[pidc_pkg::IRECIP_SHIFT +: pidc_pkg::DIGIT_WIDTH];
   assign dig_rem = dig_x - DIGX_WIDTH'(dig_q) * DIGX_WIDTH'(pidc_pkg::INTEG_DIVISOR);

   always_comb begin
      if (neg_ff) begin
         deriv_sat = (dvd_ff > QUOT_NEG_LIMIT) ? pidc_pkg::DRIVE_MIN
                                               : $signed(32'd0 - dvd_ff[31:0]);
      end else begin
         deriv_sat = (dvd_ff > QUOT_POS_LIMIT) ? pidc_pkg::DRIVE_MAX
                                               : $signed(dvd_ff[31:0]);
      end
   end

   assign quot_ext = 64'(iq_ff);
   assign iterm    = neg_ff ? $signed(64'd0 - quot_ext) : $signed(quot_ext);

   always_comb begin
      dterm_sat = scaled;
      if (scaled > pidc_pkg::DTERM_LIMIT) dterm_sat = pidc_pkg::DTERM_LIMIT;
      else if (scaled < -pidc_pkg::DTERM_LIMIT) dterm_sat = -pidc_pkg::DTERM_LIMIT;
   end

   assign drive_sum = acc_ff;

   always_comb begin
      drive_flag = 1'b0;
      drive_val  = $signed(drive_sum[31:0]);
      if (drive_sum > $signed({{32{1'b0}}, pidc_pkg::DRIVE_MAX})) begin
         drive_flag = 1'b1;
         drive_val  = pidc_pkg::DRIVE_MAX;
      end else if (drive_sum < $signed({{32{1'b1}}, pidc_pkg::DRIVE_MIN})) begin
         drive_flag = 1'b1;
         drive_val  = pidc_pkg::DRIVE_MIN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= '0;
         integ_ff <= '0;
      end else begin
         if (state_ff == pidc_pkg::ST_INTEG) prev_ff <= err_ff;
         if (state_ff == pidc_pkg::ST_CLAMP) integ_ff <= $signed(clamp_val[31:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (div_step) begin
         rem_ff <= rem_diff[30:0];
         dvd_ff <= {dvd_ff[DIV_WIDTH-2:0], rem_fits};
         cnt_ff <= cnt_ff - CNT_WIDTH'(1);
      end
      case (state_ff)
         pidc_pkg::ST_IDLE: begin
            err_ff  <= req_error_sample;
            sum_ff  <= $signed({prev_ff[31], prev_ff}) + $signed({req_error_sample[31],
                                                                  req_error_sample});
            diff_ff <= $signed({req_error_sample[31], req_error_sample})
                       - $signed({prev_ff[31], prev_ff});
         end
         pidc_pkg::ST_MUL_AREA: prod_ff <= mul_prod;
         pidc_pkg::ST_INTEG: begin
            acc_ff     <= integ_sum;
            rem_ff     <= '0;
            divisor_ff <= dt_eff;
            dvd_ff     <= DIV_WIDTH'(diff_mag) << (DIV_WIDTH - 33);
            cnt_ff     <= CNT_WIDTH'(DERIV_WIDTH);
            neg_ff     <= diff_ff[32];
         end
         pidc_pkg::ST_DERIV: begin
            deriv_ff <= deriv_sat;
            prod_ff  <= mul_prod;
         end
         pidc_pkg::ST_MUL_I: begin
            acc_ff  <= scaled;
            prod_ff <= mul_prod;
         end
         pidc_pkg::ST_LOAD_I: begin
            rem_ff <= '0;
            iq_ff  <= IQ_WIDTH'(scaled_mag[ITERM_WIDTH-1:0]);
            cnt_ff <= CNT_WIDTH'(IDIGITS);
            neg_ff <= scaled[63];
         end
         pidc_pkg::ST_DIG_MUL: prod_ff <= mul_prod;
         pidc_pkg::ST_DIG_SUB: begin
            rem_ff <= 31'(dig_rem);
            iq_ff  <= {iq_ff[IQ_WIDTH-pidc_pkg::DIGIT_WIDTH-1:0], dig_q};
            cnt_ff <= cnt_ff - CNT_WIDTH'(1);
         end
         pidc_pkg::ST_IQUOT: begin
            acc_ff  <= acc_ff + iterm;
            prod_ff <= mul_prod;
         end
         pidc_pkg::ST_DTERM: term_ff <= dterm_sat;
         pidc_pkg::ST_DM1:   acc_ff <= acc_ff + (term_ff <<< 10);
         pidc_pkg::ST_DM2:   acc_ff <= acc_ff - (term_ff <<< 4);
         pidc_pkg::ST_DM3:   acc_ff <= acc_ff - (term_ff <<< 3);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_value_ff <= drive_val;
         rsp_sat_ff   <= drive_flag;
      end
   end

endmodule

// ===== hw/rtl/pidc_checker.sv =====
`include "pid_controller_clamped_integrator_assert.svh"

module pidc_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [31:0] rsp_drive_value,
   input logic               rsp_drive_saturated
);

   // A stalled response beat holds its payload.
   `PIDC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_drive_value) && $stable(rsp_drive_saturated))

   // Once a request beat is taken, the block is busy in the next cycle.
   `PIDC_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)

   // A response cannot appear in the cycle right after a request is taken.
   `PIDC_ASSERT_NEXT(a_no_early_rsp, clock, reset, req_valid && !req_stall, !$rose(rsp_valid))

   // A saturated response carries one of the two range limits.
   `PIDC_ASSERT_IMPLY(a_sat_value, clock, reset, rsp_valid && rsp_drive_saturated, (rsp_drive_value == 32'sh7fff_ffff) || (rsp_drive_value == 32'sh8000_0000))

endmodule

bind pid_controller_clamped_integrator pidc_checker u_pidc_checker (.*);

// ===== bench/tb_pid_controller_clamped_integrator.sv =====
module tb_pid_controller_clamped_integrator;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC_BITS = 16;
   localparam int SETTLE_CYCLES = 120;
   localparam int HOLD_CYCLES = 400;
   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_ITEMS = 78;
   localparam longint INTEG_SCALE = 1000;
   localparam logic [pidc_pkg::CSR_INDEX_WIDTH-1:0] CSR_SPARE_LOW = 3'd6;
   localparam logic [pidc_pkg::CSR_INDEX_WIDTH-1:0] CSR_SPARE_HIGH = 3'd7;
   localparam logic signed [31:0] WORD_MAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] ONE = 32'sh0001_0000;

   typedef struct packed {
      logic signed [31:0] value;
      logic               saturated;
   } drive_beat_type;

   typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_pattern_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic signed [31:0]         req_error_sample = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic signed [31:0]         rsp_drive_value;
   logic                       rsp_drive_saturated;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [pidc_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [31:0]                csr_data = '0;

   logic signed [31:0] gain_p, gain_i, gain_d, clamp_low, clamp_high;
   logic [30:0]        step_period;
   logic signed [31:0] last_error, integ_sum;

   drive_beat_type     drive_expected[$];
   int                 mismatches = 0;
   int                 burst_left = 0;
   bit                 tx_paced = 1'b1;
   int                 rsp_hold_cycles = 0;
   rx_pattern_type     rx_mode = RX_OPEN;
   int                 rx_mode_left = 0;
   logic signed [31:0] walk_error = '0;

   always #2 clock = ~clock;

   pid_controller_clamped_integrator #(
      .FRAC_BITS(FRAC_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_error_sample(req_error_sample),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_drive_value(rsp_drive_value),
      .rsp_drive_saturated(rsp_drive_saturated),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   task automatic reset_controller();
      gain_p = '0;
      gain_i = '0;
      gain_d = '0;
      clamp_low = WORD_MIN;
      clamp_high = WORD_MAX;
      step_period = 31'd1 << FRAC_BITS;
      last_error = '0;
      integ_sum = '0;
   endtask

   function automatic drive_beat_type advance_controller(input logic signed [31:0] err);
      drive_beat_type beat;
      longint dt, acc, rate, p_term, i_term, d_term, total;
      dt = (step_period == '0) ? 64'sd1 : longint'(step_period);
      acc = longint'(integ_sum)
          + (((longint'(last_error) + longint'(err)) * dt) >>> (FRAC_BITS + 1));
      if (acc < clamp_low) acc = clamp_low;
      if (acc > clamp_high) acc = clamp_high;
      integ_sum = acc[31:0];
      rate = ((longint'(err) - longint'(last_error)) * (64'sd1 <<< FRAC_BITS)) / dt;
      if (rate > WORD_MAX) rate = WORD_MAX;
      if (rate < WORD_MIN) rate = WORD_MIN;
      last_error = err;
      p_term = (longint'(gain_p) * longint'(err)) >>> FRAC_BITS;
      i_term = ((longint'(gain_i) * longint'(integ_sum)) >>> FRAC_BITS) / INTEG_SCALE;
      d_term = (longint'(gain_d) * rate) >>> FRAC_BITS;
      if (d_term > pidc_pkg::DTERM_LIMIT) d_term = pidc_pkg::DTERM_LIMIT;
      if (d_term < -pidc_pkg::DTERM_LIMIT) d_term = -pidc_pkg::DTERM_LIMIT;
      d_term = d_term * INTEG_SCALE;
      total = p_term + i_term + d_term;
      beat.saturated = (total > pidc_pkg::DRIVE_MAX) || (total < pidc_pkg::DRIVE_MIN);
      if (total > pidc_pkg::DRIVE_MAX) total = pidc_pkg::DRIVE_MAX;
      if (total < pidc_pkg::DRIVE_MIN) total = pidc_pkg::DRIVE_MIN;
      beat.value = total[31:0];
      return beat;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      mismatches++;
      if (mismatches <= 10)
         $display("%s mismatch: expected %h, got %h at %0t", what, want, got, $time);
   endtask

   task automatic send_error(input logic signed [31:0] err);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = 0;
         if (tx_paced)
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 150) : $urandom_range(0, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_error_sample <= err;
      do @(posedge clock); while (req_stall);
      drive_expected.push_back(advance_controller(err));
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      burst_left = 0;
      while (drive_expected.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic write_register(input logic [pidc_pkg::CSR_INDEX_WIDTH-1:0] index,
                                 input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      case (index)
         pidc_pkg::CSR_PROP_GAIN:        gain_p = data;
         pidc_pkg::CSR_INTEG_GAIN:       gain_i = data;
         pidc_pkg::CSR_DERIV_GAIN:       gain_d = data;
         pidc_pkg::CSR_INTEG_LOW_LIMIT:  clamp_low = data;
         pidc_pkg::CSR_INTEG_HIGH_LIMIT: clamp_high = data;
         pidc_pkg::CSR_SAMPLE_PERIOD:    step_period = data[30:0];
         default: ;
      endcase
   endtask

   task automatic program_controller(input logic [31:0] p, input logic [31:0] i,
                                     input logic [31:0] d, input logic [31:0] lo,
                                     input logic [31:0] hi, input logic [31:0] period);
      write_register(pidc_pkg::CSR_PROP_GAIN, p);
      write_register(pidc_pkg::CSR_INTEG_GAIN, i);
      write_register(pidc_pkg::CSR_DERIV_GAIN, d);
      write_register(pidc_pkg::CSR_INTEG_LOW_LIMIT, lo);
      write_register(pidc_pkg::CSR_INTEG_HIGH_LIMIT, hi);
      write_register(pidc_pkg::CSR_SAMPLE_PERIOD, period);
      csr_valid <= 1'b0;
   endtask

   function automatic logic signed [31:0] pick_error();
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return ($urandom_range(0, 1) != 0) ? WORD_MAX : WORD_MIN;
         2, 3: return int'($urandom_range(0, 32'h1F_FFFF)) - 32'sh10_0000;
         default: begin
            walk_error = walk_error - (walk_error >>> 6)
                       + (int'($urandom_range(0, 32'h3FFF)) - 32'sh2000);
            return walk_error;
         end
      endcase
   endfunction

   function automatic logic [31:0] pick_gain();
      case ($urandom_range(0, 7))
         0: return WORD_MAX;
         1: return WORD_MIN;
         2: return '0;
         3, 4: return $urandom;
         default: return int'($urandom_range(0, 32'h7_FFFF)) - 32'sh4_0000;
      endcase
   endfunction

   function automatic logic [31:0] pick_limit();
      case ($urandom_range(0, 5))
         0: return WORD_MAX;
         1: return WORD_MIN;
         2: return $urandom;
         default: return int'($urandom_range(0, 32'h1FF_FFFF)) - 32'sh100_0000;
      endcase
   endfunction

   function automatic logic [31:0] pick_period();
      case ($urandom_range(0, 6))
         0: return '0;
         1: return 32'd1;
         2: return ONE;
         3: return $urandom;
         default: return {1'($urandom_range(0, 1)), 31'($urandom_range(32'h1000, 32'h4_0000))};
      endcase
   endfunction

   always @(posedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         rsp_hold_cycles--;
      end else begin
         if (rx_mode_left == 0) begin
            rx_mode = rx_pattern_type'($urandom_range(0, 3));
            rx_mode_left = $urandom_range(50, 600);
         end
         rx_mode_left--;
         case (rx_mode)
            RX_OPEN:  rsp_stall <= 1'b0;
            RX_LIGHT: rsp_stall <= ($urandom_range(0, 7) == 0);
            RX_HEAVY: rsp_stall <= ($urandom_range(0, 1) == 0);
            default:  rsp_stall <= (rx_mode_left % 5) < 2;
         endcase
      end
   end

   always @(posedge clock) begin
      drive_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (drive_expected.size() == 0) begin
            report_mismatch("unexpected beat", 'x, rsp_drive_value);
         end else begin
            want = drive_expected.pop_front();
            if (rsp_drive_value !== want.value)
               report_mismatch("drive_value", want.value, rsp_drive_value);
            if (rsp_drive_saturated !== want.saturated)
               report_mismatch("drive_saturated", want.saturated, rsp_drive_saturated);
         end
      end
   end

   task automatic test_reset_defaults();
      send_error(WORD_MAX);
      send_error(WORD_MIN);
      send_error(32'sh0001_2345);
   endtask

   task automatic test_field_extremes();
      wait_for_results();
      program_controller(ONE, 32'sh0100_0000, 32'sh0000_0100, WORD_MIN, WORD_MAX, ONE);
      send_error(WORD_MAX);
      send_error(WORD_MIN);
      send_error(WORD_MAX);
      send_error('0);
      send_error(-32'sd1);
   endtask

   task automatic test_integrator_clamp();
      wait_for_results();
      program_controller('0, ONE, '0, -32'sh3_0000, 32'sh5_0000, 32'h8000);
      repeat (3) send_error(32'sh4_0000);
      repeat (2) send_error(-32'sh10_0000);
   endtask

   // With the floor above the ceiling the integrator must settle on the ceiling.
   task automatic test_inverted_limits();
      wait_for_results();
      program_controller(ONE, ONE, '0, 32'sh2_0000, -32'sh2_0000, ONE);
      repeat (3) send_error(pick_error());
   endtask

   task automatic test_sample_period_edges();
      wait_for_results();
      program_controller(ONE, ONE, ONE, WORD_MIN, WORD_MAX, '0);
      send_error(32'sd1);
      send_error(-32'sd1);
      wait_for_results();
      write_register(pidc_pkg::CSR_SAMPLE_PERIOD, '1);
      csr_valid <= 1'b0;
      send_error(WORD_MAX);
      send_error(WORD_MIN);
   endtask

   task automatic test_output_saturation();
      wait_for_results();
      program_controller(WORD_MAX, '0, WORD_MAX, WORD_MIN, WORD_MAX, ONE);
      send_error(WORD_MAX);
      send_error(WORD_MIN);
      send_error('0);
   endtask

   task automatic test_spare_registers();
      wait_for_results();
      write_register(CSR_SPARE_LOW, $urandom);
      write_register(CSR_SPARE_HIGH, $urandom);
      csr_valid <= 1'b0;
      send_error(pick_error());
      send_error(pick_error());
   endtask

   // The receiver holds off long enough for the block to fill and stall its input.
   task automatic test_backpressure();
      wait_for_results();
      program_controller(ONE, ONE, 32'sh0000_1000, -32'sh100_0000, 32'sh100_0000, ONE);
      tx_paced = 1'b0;
      rsp_hold_cycles = HOLD_CYCLES;
      repeat (10) send_error(pick_error());
      tx_paced = 1'b1;
      wait_for_results();
   endtask

   task automatic test_random_phases();
      logic [31:0] lo, hi, swap;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_for_results();
         lo = pick_limit();
         hi = pick_limit();
         if ($signed(lo) > $signed(hi) && $urandom_range(0, 3) != 0) begin
            swap = lo;
            lo = hi;
            hi = swap;
         end
         case (phase)
            0: program_controller(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, '1);
            1: program_controller(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, '0);
            default: program_controller(pick_gain(), pick_gain(), pick_gain(), lo, hi,
                                        pick_period());
         endcase
         tx_paced = ($urandom_range(0, 3) != 0);
         repeat (PHASE_ITEMS) send_error(pick_error());
      end
      tx_paced = 1'b1;
   endtask

   initial begin
      reset_controller();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_field_extremes();
      test_integrator_clamp();
      test_inverted_limits();
      test_sample_period_edges();
      test_output_saturation();
      test_spare_registers();
      test_backpressure();
      test_random_phases();
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && drive_expected.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      #8_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
